### rtl/kpc_pkg.sv
// Package for the k-mer pattern counter: opcodes, register indexes, symbol codes,
// default sizes and the counter address function. No dependencies.
package kpc_pkg;

   localparam int unsigned MAX_BLOCKS_DEF = 4096;
   localparam int unsigned MAX_ORDER_DEF  = 3;

   localparam int unsigned POS_W   = 31;
   localparam int unsigned CNT_W   = 32;
   localparam int unsigned BIDX_W  = 12;
   localparam int unsigned CSR_IDX_W  = 4;
   localparam int unsigned CSR_DATA_W = 13;

   typedef logic [1:0] opcode_type;
   localparam opcode_type OP_LOAD = 2'd0;
   localparam opcode_type OP_FEED = 2'd1;
   localparam opcode_type OP_READ = 2'd2;
   localparam opcode_type OP_NOP  = 2'd3;

   typedef logic [CSR_IDX_W-1:0] csr_index_type;
   localparam csr_index_type REG_ORDER_COUNT = 4'd0;
   localparam csr_index_type REG_BLOCK_COUNT = 4'd1;

   localparam logic [1:0] SYM_T   = 2'd0;
   localparam logic [1:0] SYM_C   = 2'd1;
   localparam logic [1:0] SYM_DOT = 2'd2;

   // counter layout: order k owns MAX_BLOCKS rows of 2^k patterns
   function automatic logic [31:0] counter_index(input logic [31:0] max_blocks,
                                                 input logic [3:0] k,
                                                 input logic [31:0] blk,
                                                 input logic [7:0] pat);
      logic [31:0] width;
      width = 32'd1 << k;
      return max_blocks * (width - 32'd2) + (blk << k) + {24'd0, pat};
   endfunction

endpackage

### rtl/kpc_if.sv
// Channel interfaces of the k-mer pattern counter: request, response, register write.
// Depends on kpc_pkg.
interface kpc_req_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  opcode;
   logic [kpc_pkg::BIDX_W-1:0]  block_index;
   logic [kpc_pkg::POS_W-1:0]   block_start;
   logic [kpc_pkg::POS_W-1:0]   block_end;
   logic [kpc_pkg::POS_W-1:0]   site_position;
   logic [1:0]                  site_symbol;
   logic                        first_of_read;
   logic [kpc_pkg::POS_W-1:0]   read_count;
   logic [2:0]                  query_order;
   logic [7:0]                  query_pattern;
   modport source (output valid, opcode, block_index, block_start, block_end, site_position,
                   site_symbol, first_of_read, read_count, query_order, query_pattern,
                   input ready);
   modport sink (input valid, opcode, block_index, block_start, block_end, site_position,
                 site_symbol, first_of_read, read_count, query_order, query_pattern,
                 output ready);
endinterface

interface kpc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [kpc_pkg::CNT_W-1:0]   count_value;
   logic [kpc_pkg::BIDX_W-1:0]  site_block;
   logic                        site_in_block;
   logic                        finished;
   modport source (output valid, count_value, site_block, site_in_block, finished,
                   input ready);
   modport sink (input valid, count_value, site_block, site_in_block, finished,
                 output ready);
endinterface

interface kpc_csr_if;
   logic                            valid;
   logic                            ready;
   logic [kpc_pkg::CSR_IDX_W-1:0]   index;
   logic [kpc_pkg::CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### rtl/kpc_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module kpc_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16,
   parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                   clock,
   input  logic                   we,
   input  logic [AW-1:0]          waddr,
   input  logic [WIDTH-1:0]       wdata,
   input  logic [AW-1:0]          raddr,
   output logic [WIDTH-1:0]       rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

### rtl/block_kmer_pattern_counter_top.sv
// Top level of the k-mer pattern counter: sequencer around border and counter RAMs.
// Depends on kpc_pkg, kpc_if and kpc_ram.

// Counts binary k-mers (C=1, T=0) of methylation reads inside sorted genomic
// blocks. Load block borders with opcode 0, feed read sites with opcode 1 and
// read counters back with opcode 2; every request word gives one response word.
// Border start and end values live in two RAMs of MAX_BLOCKS entries, the
// counters in one RAM of MAX_BLOCKS*(2^(MAX_ORDER+1)-2) words (57344 with the
// defaults). After reset the counter RAM is cleared one word a cycle, so the
// request side stays not-ready until the clear is done; register writes are taken
// throughout. Steps per word, each RAM read registered: a load, a no-op or a
// site after the finished flag goes straight to the response; a counter read
// reads the counter RAM unless the query lies outside the stored counters; a
// fed site checks block ends until the pointer settles, then reads the block
// start and does one read-modify-write per counter updated (one per order, up
// to min(order_count, MAX_ORDER)), or stops when the pointer ends past the last
// block; a read's first site first looks up the last end. A waiting response
// holds only the final step; the next request is taken once the sequencer is idle.
module block_kmer_pattern_counter_top #(
   parameter int unsigned MAX_BLOCKS = kpc_pkg::MAX_BLOCKS_DEF,
   parameter int unsigned MAX_ORDER  = kpc_pkg::MAX_ORDER_DEF
) (
   input  logic clock,
   input  logic reset,
   kpc_req_if.sink   req_chan,
   kpc_rsp_if.source rsp_chan,
   kpc_csr_if.sink   csr_chan
);
   localparam int unsigned AW    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int unsigned PW    = $clog2(MAX_BLOCKS + 1);
   localparam int unsigned CBW   = (PW > 13) ? PW : 13;
   localparam int unsigned TOTAL = MAX_BLOCKS * ((2 << MAX_ORDER) - 2);
   localparam int unsigned CAW   = (TOTAL > 1) ? $clog2(TOTAL) : 1;
   localparam int unsigned RW    = $clog2(MAX_ORDER + 1);
   localparam int unsigned POS_W = kpc_pkg::POS_W;

   // sequencer states
   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_LAST_RD  = 4'd2;
   localparam logic [3:0] S_LAST_CHK = 4'd3;
   localparam logic [3:0] S_ADV_RD   = 4'd4;
   localparam logic [3:0] S_ADV_CHK  = 4'd5;
   localparam logic [3:0] S_ST_RD    = 4'd6;
   localparam logic [3:0] S_ST_CHK   = 4'd7;
   localparam logic [3:0] S_CNT_RD   = 4'd8;
   localparam logic [3:0] S_CNT_WR   = 4'd9;
   localparam logic [3:0] S_Q_RD     = 4'd10;
   localparam logic [3:0] S_Q_DATA   = 4'd11;
   localparam logic [3:0] S_FIN      = 4'd12;

   logic [3:0] state_ff, state_in;

   // configuration
   logic [3:0]  order_count_ff, order_count_in;
   logic [12:0] block_count_ff, block_count_in;

   // persistent block/window state
   logic [PW-1:0]        read_ptr_ff, read_ptr_in;
   logic [PW-1:0]        site_ptr_ff, site_ptr_in;
   logic [PW-1:0]        window_ff, window_in;
   logic [MAX_ORDER-1:0] bits_ff, bits_in;
   logic [RW-1:0]        run_ff, run_in;
   logic [POS_W-1:0]     count_ff, count_in;
   logic                 done_ff, done_in;

   // working registers
   logic [PW-1:0]  wp_ff, wp_in;
   logic [3:0]     k_ff, k_in;
   logic [3:0]     lim_ff, lim_in;
   logic [CAW-1:0] clr_ff, clr_in;

   // latched request word
   logic [11:0]      bidx_ff, bidx_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [1:0]       sym_ff, sym_in;
   logic             first_ff, first_in;
   logic [POS_W-1:0] rcnt_ff, rcnt_in;
   logic [2:0]       qord_ff, qord_in;
   logic [7:0]       qpat_ff, qpat_in;

   // result under construction and output register
   logic [31:0] value_ff, value_in;
   logic [11:0] sblock_ff, sblock_in;
   logic        inblk_ff, inblk_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_value_ff, rsp_value_in;
   logic [11:0] rsp_sblock_ff, rsp_sblock_in;
   logic        rsp_inblk_ff, rsp_inblk_in;
   logic        rsp_fin_ff, rsp_fin_in;

   // RAM ports
   logic             brd_we;
   logic [AW-1:0]    brd_waddr;
   logic [AW-1:0]    end_raddr;
   logic [POS_W-1:0] end_rdata, start_rdata;
   logic             cnt_we;
   logic [CAW-1:0]   cnt_waddr, cnt_raddr;
   logic [31:0]      cnt_wdata, cnt_rdata;

   // derived values
   logic [CBW-1:0]       bc_ext;
   logic [PW-1:0]        ub;
   logic [PW-1:0]        ub_m1;
   logic [3:0]           uo;
   logic                 accept;
   logic                 load_ok;
   logic                 query_ok;
   logic [3:0]           qk;
   logic [8:0]           qlimit;
   logic [CAW-1:0]       q_addr, upd_addr;
   logic [31:0]          q_idx, upd_idx;
   logic [MAX_ORDER:0]   kmask;
   logic [MAX_ORDER:0]   bits_shift;
   logic [MAX_ORDER-1:0] bits_base;
   logic [RW-1:0]        run_base, run_next;
   logic [3:0]           run_ext;
   logic                 inb;
   logic                 out_free;

   always_comb begin
      bc_ext = CBW'(block_count_ff);
      ub     = (bc_ext > CBW'(MAX_BLOCKS)) ? PW'(MAX_BLOCKS) : PW'(bc_ext);
      ub_m1  = ub - PW'(1);
      uo     = (order_count_ff > 4'(MAX_ORDER)) ? 4'(MAX_ORDER) : order_count_ff;
   end

   assign accept   = req_chan.valid && req_chan.ready;
   assign load_ok  = {20'd0, req_chan.block_index} < 32'(MAX_BLOCKS);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // counter read query
   assign qk       = {1'b0, qord_ff} + 4'd1;
   assign qlimit   = 9'd1 << qk;
   assign query_ok = (qk <= 4'(MAX_ORDER)) && ({20'd0, bidx_ff} < 32'(MAX_BLOCKS))
                     && ({1'b0, qpat_ff} < qlimit);
   assign q_idx    = kpc_pkg::counter_index(32'(MAX_BLOCKS), qk, {20'd0, bidx_ff}, qpat_ff);
   assign q_addr   = q_idx[CAW-1:0];

   // counter update address for order k_ff
   assign kmask   = ((MAX_ORDER+1)'(1) << k_ff) - (MAX_ORDER+1)'(1);
   assign upd_idx = kpc_pkg::counter_index(32'(MAX_BLOCKS), k_ff, 32'(wp_ff),
                                           8'({1'b0, bits_ff} & kmask));
   assign upd_addr = upd_idx[CAW-1:0];

   // window extension for an in-block non-dot site
   assign bits_base  = (wp_ff != window_ff) ? '0 : bits_ff;
   assign run_base   = (wp_ff != window_ff) ? '0 : run_ff;
   assign bits_shift = {bits_base, sym_ff[0]};
   assign run_next   = (run_base < RW'(MAX_ORDER)) ? run_base + RW'(1) : run_base;
   assign run_ext    = 4'(run_next);
   assign inb        = (state_ff == S_ST_CHK) && (pos_ff >= start_rdata);

   assign req_chan.ready = (state_ff == S_IDLE);
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.count_value   = rsp_value_ff;
   assign rsp_chan.site_block    = rsp_sblock_ff;
   assign rsp_chan.site_in_block = rsp_inblk_ff;
   assign rsp_chan.finished      = rsp_fin_ff;

   // RAM port selection
   assign brd_we    = accept && (req_chan.opcode == kpc_pkg::OP_LOAD) && load_ok;
   assign brd_waddr = AW'(req_chan.block_index);
   assign end_raddr = (state_ff == S_LAST_RD) ? ub_m1[AW-1:0] : wp_ff[AW-1:0];
   assign cnt_we    = (state_ff == S_CLEAR) || (state_ff == S_CNT_WR);
   assign cnt_waddr = (state_ff == S_CLEAR) ? clr_ff : upd_addr;
   assign cnt_wdata = (state_ff == S_CLEAR) ? 32'd0 : cnt_rdata + {1'b0, count_ff};
   assign cnt_raddr = (state_ff == S_Q_RD) ? q_addr : upd_addr;

   always_comb begin
      state_in       = state_ff;
      order_count_in = order_count_ff;
      block_count_in = block_count_ff;
      read_ptr_in    = read_ptr_ff;
      site_ptr_in    = site_ptr_ff;
      window_in      = window_ff;
      bits_in        = bits_ff;
      run_in         = run_ff;
      count_in       = count_ff;
      done_in        = done_ff;
      wp_in          = wp_ff;
      k_in           = k_ff;
      lim_in         = lim_ff;
      clr_in         = clr_ff;
      bidx_in        = bidx_ff;
      pos_in         = pos_ff;
      sym_in         = sym_ff;
      first_in       = first_ff;
      rcnt_in        = rcnt_ff;
      qord_in        = qord_ff;
      qpat_in        = qpat_ff;
      value_in       = value_ff;
      sblock_in      = sblock_ff;
      inblk_in       = inblk_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_sblock_in  = rsp_sblock_ff;
      rsp_inblk_in   = rsp_inblk_ff;
      rsp_fin_in     = rsp_fin_ff;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_chan.valid) begin
         priority if (csr_chan.index == kpc_pkg::REG_ORDER_COUNT) begin
            order_count_in = csr_chan.data[3:0];
         end else if (csr_chan.index == kpc_pkg::REG_BLOCK_COUNT) begin
            block_count_in = csr_chan.data;
         end
      end

      unique case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + CAW'(1);
            if (clr_ff == CAW'(TOTAL - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               bidx_in   = req_chan.block_index;
               pos_in    = req_chan.site_position;
               sym_in    = req_chan.site_symbol;
               first_in  = req_chan.first_of_read;
               rcnt_in   = req_chan.read_count;
               qord_in   = req_chan.query_order;
               qpat_in   = req_chan.query_pattern;
               value_in  = 32'd0;
               sblock_in = 12'd0;
               inblk_in  = 1'b0;
               unique case (req_chan.opcode)
                  kpc_pkg::OP_FEED: begin
                     if (done_ff) begin
                        state_in = S_FIN;
                     end else if (req_chan.first_of_read) begin
                        state_in = S_LAST_RD;
                        if (ub == '0) begin
                           // no blocks: last end is zero
                           if (req_chan.site_position != '0) begin
                              done_in  = 1'b1;
                              state_in = S_FIN;
                           end else begin
                              wp_in    = read_ptr_ff;
                              state_in = S_ADV_RD;
                           end
                        end
                     end else begin
                        wp_in    = site_ptr_ff;
                        state_in = S_ADV_RD;
                     end
                  end
                  kpc_pkg::OP_READ: state_in = S_Q_RD;
                  default:          state_in = S_FIN;
               endcase
            end
         end
         S_LAST_RD: state_in = S_LAST_CHK;
         S_LAST_CHK: begin
            if (pos_ff > end_rdata) begin
               done_in  = 1'b1;
               state_in = S_FIN;
            end else begin
               wp_in    = read_ptr_ff;
               state_in = S_ADV_RD;
            end
         end
         S_ADV_RD: begin
            if (wp_ff < ub) begin
               state_in = S_ADV_CHK;
            end else begin
               state_in = S_ST_RD;
            end
         end
         S_ADV_CHK: begin
            if (pos_ff >= end_rdata) begin
               wp_in    = wp_ff + PW'(1);
               state_in = S_ADV_RD;
            end else begin
               state_in = S_ST_RD;
            end
         end
         S_ST_RD, S_ST_CHK: begin
            if ((state_ff == S_ST_RD) && (wp_ff < ub)) begin
               // pointer settled; commit it and fetch the block start
               state_in = S_ST_CHK;
            end else begin
               state_in = S_FIN;
               if (!inb || sym_ff[1]) begin
                  run_in  = '0;
                  bits_in = '0;
                  if (inb) begin
                     window_in = wp_ff;
                  end
               end else begin
                  window_in = wp_ff;
                  bits_in   = bits_shift[MAX_ORDER-1:0];
                  run_in    = run_next;
                  lim_in    = (uo < run_ext) ? uo : run_ext;
                  k_in      = 4'd1;
                  sblock_in = 12'(wp_ff);
                  inblk_in  = 1'b1;
                  if (((uo < run_ext) ? uo : run_ext) != 4'd0) begin
                     state_in = S_CNT_RD;
                  end
               end
            end
            if (state_ff == S_ST_RD) begin
               site_ptr_in = wp_ff;
               if (first_ff) begin
                  read_ptr_in = wp_ff;
                  count_in    = rcnt_ff;
                  // new read: window restarts (a not-in-block site clears it anyway)
                  if (wp_ff < ub) begin
                     run_in  = '0;
                     bits_in = '0;
                  end
               end
            end
         end
         S_CNT_RD: state_in = S_CNT_WR;
         S_CNT_WR: begin
            if (k_ff == lim_ff) begin
               state_in = S_FIN;
            end else begin
               k_in     = k_ff + 4'd1;
               state_in = S_CNT_RD;
            end
         end
         S_Q_RD: begin
            state_in = query_ok ? S_Q_DATA : S_FIN;
         end
         S_Q_DATA: begin
            value_in = cnt_rdata;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = value_ff;
               rsp_sblock_in = sblock_ff;
               rsp_inblk_in  = inblk_ff;
               rsp_fin_in    = done_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Window state for a new read is cleared in S_ST_RD before the site is
   // applied in S_ST_CHK; when the site has no block the apply path clears it.

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         order_count_ff <= 4'd3;
         block_count_ff <= 13'd1;
         read_ptr_ff    <= '0;
         site_ptr_ff    <= '0;
         window_ff      <= '0;
         bits_ff        <= '0;
         run_ff         <= '0;
         count_ff       <= '0;
         done_ff        <= 1'b0;
         clr_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         order_count_ff <= order_count_in;
         block_count_ff <= block_count_in;
         read_ptr_ff    <= read_ptr_in;
         site_ptr_ff    <= site_ptr_in;
         window_ff      <= window_in;
         bits_ff        <= bits_in;
         run_ff         <= run_in;
         count_ff       <= count_in;
         done_ff        <= done_in;
         clr_ff         <= clr_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wp_ff         <= wp_in;
      k_ff          <= k_in;
      lim_ff        <= lim_in;
      bidx_ff       <= bidx_in;
      pos_ff        <= pos_in;
      sym_ff        <= sym_in;
      first_ff      <= first_in;
      rcnt_ff       <= rcnt_in;
      qord_ff       <= qord_in;
      qpat_ff       <= qpat_in;
      value_ff      <= value_in;
      sblock_ff     <= sblock_in;
      inblk_ff      <= inblk_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_sblock_ff <= rsp_sblock_in;
      rsp_inblk_ff  <= rsp_inblk_in;
      rsp_fin_ff    <= rsp_fin_in;
   end

   kpc_ram #(.WIDTH(POS_W), .DEPTH(MAX_BLOCKS)) u_starts (
      .clock (clock),
      .we    (brd_we),
      .waddr (brd_waddr),
      .wdata (req_chan.block_start),
      .raddr (wp_ff[AW-1:0]),
      .rdata (start_rdata)
   );

   kpc_ram #(.WIDTH(POS_W), .DEPTH(MAX_BLOCKS)) u_ends (
      .clock (clock),
      .we    (brd_we),
      .waddr (brd_waddr),
      .wdata (req_chan.block_end),
      .raddr (end_raddr),
      .rdata (end_rdata)
   );

   kpc_ram #(.WIDTH(32), .DEPTH(TOTAL)) u_counters (
      .clock (clock),
      .we    (cnt_we),
      .waddr (cnt_waddr),
      .wdata (cnt_wdata),
      .raddr (cnt_raddr),
      .rdata (cnt_rdata)
   );

endmodule
